// ===== sv/otrb_pkg.sv =====
// ----------------------------------------------------------------------------
// otrb_pkg
// Shared types and constants for the overwriting trace ring buffer.
// ----------------------------------------------------------------------------
package otrb_pkg;

  localparam int unsigned CAPACITY_DEF     = 64;
  localparam int unsigned PAYLOAD_BITS_DEF = 64;

  localparam int unsigned SEQ_W   = 64;
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned CNT_W   = 7;

  typedef enum logic {
    OP_PUSH     = 1'b0,
    OP_SNAPSHOT = 1'b1
  } op_e;

  typedef struct packed {
    logic               operation;
    logic [LEVEL_W-1:0] level;
    logic [WORD_W-1:0]  payload;
    logic [CNT_W-1:0]   max_count;
  } otrb_in_t;

  typedef struct packed {
    logic               entry_valid;
    logic [SEQ_W-1:0]   sequence_res;
    logic [LEVEL_W-1:0] entry_level;
    logic [WORD_W-1:0]  entry_payload;
    logic [CNT_W-1:0]   stored_count;
    logic [WORD_W-1:0]  dropped_count;
    logic               last;
  } otrb_out_t;

  // controller -> datapath
  typedef struct packed {
    logic push;        // store the input item, emit its result
    logic snap_empty;  // emit the empty snapshot result
    logic snap_start;  // latch snapshot window, issue first read
    logic snap_load;   // move read data into the output register
    logic out_clear;   // output item taken by the receiver
  } otrb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_valid;   // output register holds an item
    logic snap_none;   // current request would return no entries
    logic remain_one;  // next snapshot load is the last one
  } otrb_sts_t;

endpackage

// ===== sv/otrb_ram.sv =====
// ----------------------------------------------------------------------------
// otrb_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module otrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/otrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// otrb_ctrl
// Controller: input handshake and snapshot readout sequencing.
// ----------------------------------------------------------------------------
module otrb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_op_i,
  output logic                in_stall_o,
  input  logic                out_stall_i,
  input  otrb_pkg::otrb_sts_t sts_i,
  output otrb_pkg::otrb_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SNAP
  } state_e;

  state_e state_q, state_d;
  logic   out_free;
  logic   take;

  // output register can be loaded this cycle
  assign out_free = !sts_i.out_valid || !out_stall_i;
  assign take     = (state_q == ST_IDLE) && in_valid_i && out_free;

  assign in_stall_o = !((state_q == ST_IDLE) && out_free);

  always_comb begin
    cmd_o            = '0;
    cmd_o.push       = take && (in_op_i == otrb_pkg::OP_PUSH);
    cmd_o.snap_empty = take && (in_op_i == otrb_pkg::OP_SNAPSHOT) && sts_i.snap_none;
    cmd_o.snap_start = take && (in_op_i == otrb_pkg::OP_SNAPSHOT) && !sts_i.snap_none;
    cmd_o.snap_load  = (state_q == ST_SNAP) && out_free;
    cmd_o.out_clear  = sts_i.out_valid && !out_stall_i;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.snap_start) begin
          state_d = ST_SNAP;
        end
      end
      ST_SNAP: begin
        if (cmd_o.snap_load && sts_i.remain_one) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/otrb_dp.sv =====
// ----------------------------------------------------------------------------
// otrb_dp
// Datapath: ring pointers, counters, entry RAM and output register.
// ----------------------------------------------------------------------------
module otrb_dp #(
  parameter int unsigned CAPACITY     = otrb_pkg::CAPACITY_DEF,
  parameter int unsigned PAYLOAD_BITS = otrb_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  otrb_pkg::otrb_in_t  in_i,
  input  otrb_pkg::otrb_cmd_t cmd_i,
  output otrb_pkg::otrb_sts_t sts_o,
  output otrb_pkg::otrb_out_t out_o
);

  localparam int unsigned PW      = $clog2(CAPACITY);
  localparam int unsigned CW      = $clog2(CAPACITY + 1);
  localparam int unsigned SW      = CW + 1;
  localparam int unsigned ENTRY_W = otrb_pkg::SEQ_W + otrb_pkg::LEVEL_W + PAYLOAD_BITS;
  localparam logic [PW-1:0] LAST_POS = PW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL     = CW'(CAPACITY);
  localparam logic [SW-1:0] CAP_S    = SW'(CAPACITY);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == LAST_POS) ? '0 : p + PW'(1);
  endfunction

  logic [PW-1:0]                oldest_q, oldest_d;
  logic [CW-1:0]                fill_q, fill_d;
  logic [otrb_pkg::WORD_W-1:0]  dropped_q, dropped_d;
  logic [otrb_pkg::SEQ_W-1:0]   next_num_q, next_num_d, next_inc;
  logic [PW-1:0]                rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]                remain_q, remain_d;
  logic                         out_valid_q;
  otrb_pkg::otrb_out_t          out_q;

  logic [PW-1:0]                wr_slot;
  logic [otrb_pkg::CNT_W-1:0]   fill_ext;
  logic [CW-1:0]                count;
  logic [CW-1:0]                skip;
  logic [SW-1:0]                start_sum;
  logic [PW-1:0]                start_pos;
  logic [PAYLOAD_BITS-1:0]      pay_kept;
  logic [ENTRY_W-1:0]           wdata, rdata;
  logic                         re;
  logic [PW-1:0]                raddr;

  // snapshot window: newest min(request, stored) entries
  assign fill_ext  = otrb_pkg::CNT_W'(fill_q);
  assign count     = (in_i.max_count < fill_ext) ? in_i.max_count[CW-1:0] : fill_q;
  assign skip      = fill_q - count;
  assign start_sum = SW'(oldest_q) + SW'(skip);
  always_comb begin
    if (start_sum >= CAP_S) begin
      start_pos = PW'(start_sum - CAP_S);
    end else begin
      start_pos = PW'(start_sum);
    end
  end

  // push slot and counter updates
  assign next_inc = next_num_q + otrb_pkg::SEQ_W'(1);
  always_comb begin
    oldest_d   = oldest_q;
    fill_d     = fill_q;
    dropped_d  = dropped_q;
    next_num_d = next_num_q;
    wr_slot    = oldest_q;
    if (fill_q < FULL) begin
      // fill_q < CAPACITY, so the sum stays below 2*CAPACITY
      if ((SW'(oldest_q) + SW'(fill_q)) >= CAP_S) begin
        wr_slot = PW'(SW'(oldest_q) + SW'(fill_q) - CAP_S);
      end else begin
        wr_slot = PW'(SW'(oldest_q) + SW'(fill_q));
      end
    end
    if (cmd_i.push) begin
      if (fill_q < FULL) begin
        fill_d = fill_q + CW'(1);
      end else begin
        oldest_d  = ptr_inc(oldest_q);
        dropped_d = dropped_q + otrb_pkg::WORD_W'(1);
      end
      // sequence skips zero on wrap
      next_num_d = (next_inc == '0) ? otrb_pkg::SEQ_W'(1) : next_inc;
    end
  end

  assign pay_kept = in_i.payload[PAYLOAD_BITS-1:0];
  assign wdata    = {next_num_q, in_i.level, pay_kept};

  // readout sequencing
  assign re    = cmd_i.snap_start || (cmd_i.snap_load && (remain_q != CW'(1)));
  assign raddr = cmd_i.snap_start ? start_pos : rd_ptr_q;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    remain_d = remain_q;
    if (cmd_i.snap_start) begin
      rd_ptr_d = ptr_inc(start_pos);
      remain_d = count;
    end else if (cmd_i.snap_load) begin
      remain_d = remain_q - CW'(1);
      if (remain_q != CW'(1)) begin
        rd_ptr_d = ptr_inc(rd_ptr_q);
      end
    end
  end

  otrb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (wr_slot),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q    <= '0;
      fill_q      <= '0;
      dropped_q   <= '0;
      next_num_q  <= otrb_pkg::SEQ_W'(1);
      remain_q    <= '0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      oldest_q   <= oldest_d;
      fill_q     <= fill_d;
      dropped_q  <= dropped_d;
      next_num_q <= next_num_d;
      remain_q   <= remain_d;
      rd_ptr_q   <= rd_ptr_d;
      if (cmd_i.push || cmd_i.snap_empty || cmd_i.snap_load) begin
        out_valid_q <= 1'b1;
      end else if (cmd_i.out_clear) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload register, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q.entry_valid   <= 1'b1;
      out_q.sequence_res  <= next_num_q;
      out_q.entry_level   <= in_i.level;
      out_q.entry_payload <= otrb_pkg::WORD_W'(pay_kept);
      out_q.stored_count  <= otrb_pkg::CNT_W'(fill_d);
      out_q.dropped_count <= dropped_d;
      out_q.last          <= 1'b1;
    end else if (cmd_i.snap_empty) begin
      out_q.entry_valid   <= 1'b0;
      out_q.sequence_res  <= '0;
      out_q.entry_level   <= '0;
      out_q.entry_payload <= '0;
      out_q.stored_count  <= fill_ext;
      out_q.dropped_count <= dropped_q;
      out_q.last          <= 1'b1;
    end else if (cmd_i.snap_load) begin
      out_q.entry_valid   <= 1'b1;
      out_q.sequence_res  <= rdata[ENTRY_W-1 -: otrb_pkg::SEQ_W];
      out_q.entry_level   <= rdata[PAYLOAD_BITS +: otrb_pkg::LEVEL_W];
      out_q.entry_payload <= otrb_pkg::WORD_W'(rdata[PAYLOAD_BITS-1:0]);
      out_q.stored_count  <= fill_ext;
      out_q.dropped_count <= dropped_q;
      out_q.last          <= (remain_q == CW'(1));
    end
  end

  assign sts_o.out_valid  = out_valid_q;
  assign sts_o.snap_none  = (count == '0);
  assign sts_o.remain_one = (remain_q == CW'(1));
  assign out_o            = out_q;

endmodule

// ===== sv/overwriting_trace_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// overwriting_trace_ring_buffer
// Fixed-capacity event ring that overwrites its oldest entry when full.
// ----------------------------------------------------------------------------
// A push stores level and payload under the next sequence number (which
// skips zero on wrap) and returns one item echoing the stored entry. When
// the ring is full the oldest entry is overwritten and the dropped count
// rises. A snapshot returns the newest min(max_count, stored) entries,
// oldest first, with last set on the final one; a snapshot that would
// return nothing gives a single item with entry_valid low. Every item also
// carries the stored and dropped counts after the operation.
// Timing: a push or an empty snapshot leaves the controller idle, so
// pushes can be taken every cycle while the output is not stalled. A
// non-empty snapshot stalls the input until its last entry is loaded: the
// entry RAM has one read port with registered read data, so the first read
// is issued on acceptance and each load moves one entry to the output while
// the next read is issued. Output stalls hold the readout. Entry storage needs
// no clearing after reset; only written entries are ever read.
// ----------------------------------------------------------------------------
module overwriting_trace_ring_buffer #(
  parameter int unsigned CAPACITY     = otrb_pkg::CAPACITY_DEF,
  parameter int unsigned PAYLOAD_BITS = otrb_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  otrb_pkg::otrb_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output otrb_pkg::otrb_out_t out_o
);

  otrb_pkg::otrb_cmd_t cmd;
  otrb_pkg::otrb_sts_t sts;

  // handshake and snapshot sequencing
  otrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_i.operation),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // pointers, counters, entry RAM, output register
  otrb_dp #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .out_o  (out_o)
  );

  assign out_valid_o = sts.out_valid;

endmodule

// ===== tb/otrb_tb_checker.sv =====
// ----------------------------------------------------------------------------
// otrb_tb_checker
// Watches both channels of the trace ring, predicts every item, compares.
// ----------------------------------------------------------------------------
// Keeps its own copy of the ring: entry storage, oldest slot, fill level,
// dropped total and next sequence number. Every accepted input item updates
// that copy and queues the items the block should return. Every accepted
// output item is checked field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module otrb_tb_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  otrb_pkg::otrb_in_t  in_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  otrb_pkg::otrb_out_t out_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int unsigned RING_DEPTH = otrb_pkg::CAPACITY_DEF;
  localparam logic [otrb_pkg::WORD_W-1:0] PAY_MASK =
    {otrb_pkg::WORD_W{1'b1}} >> (otrb_pkg::WORD_W - otrb_pkg::PAYLOAD_BITS_DEF);

  logic [otrb_pkg::SEQ_W-1:0]   seq_mem [RING_DEPTH];
  logic [otrb_pkg::LEVEL_W-1:0] lvl_mem [RING_DEPTH];
  logic [otrb_pkg::WORD_W-1:0]  pay_mem [RING_DEPTH];
  int unsigned                  head     = 0;  // slot of the oldest entry
  int unsigned                  fill     = 0;
  logic [otrb_pkg::WORD_W-1:0]  dropped  = '0;
  logic [otrb_pkg::SEQ_W-1:0]   next_seq = otrb_pkg::SEQ_W'(1);
  otrb_pkg::otrb_out_t          readout_q[$];
  int                           errors   = 0;

  task automatic queue_result(input logic vld, input logic [otrb_pkg::SEQ_W-1:0] seq,
                              input logic [otrb_pkg::LEVEL_W-1:0] lvl,
                              input logic [otrb_pkg::WORD_W-1:0] pay, input logic fin);
    otrb_pkg::otrb_out_t res;
    res.entry_valid   = vld;
    res.sequence_res  = seq;
    res.entry_level   = lvl;
    res.entry_payload = pay;
    res.stored_count  = otrb_pkg::CNT_W'(fill);
    res.dropped_count = dropped;
    res.last          = fin;
    readout_q = {readout_q, res};
  endtask

  task automatic apply_ring_op(input otrb_pkg::otrb_in_t item);
    int unsigned slot;
    int unsigned want;
    int unsigned count;
    int unsigned skip;
    if (otrb_pkg::op_e'(item.operation) == otrb_pkg::OP_PUSH) begin
      if (fill < RING_DEPTH) begin
        slot = (head + fill) % RING_DEPTH;
        fill++;
      end else begin
        // full: overwrite the oldest entry
        slot    = head;
        head    = (head + 1) % RING_DEPTH;
        dropped = dropped + otrb_pkg::WORD_W'(1);
      end
      seq_mem[slot] = next_seq;
      lvl_mem[slot] = item.level;
      pay_mem[slot] = item.payload & PAY_MASK;
      next_seq      = next_seq + otrb_pkg::SEQ_W'(1);
      if (next_seq == '0) next_seq = otrb_pkg::SEQ_W'(1);
      queue_result(1'b1, seq_mem[slot], lvl_mem[slot], pay_mem[slot], 1'b1);
    end else begin
      want  = 32'(item.max_count);
      count = (want < fill) ? want : fill;
      skip  = fill - count;
      if (count == 0) begin
        queue_result(1'b0, '0, '0, '0, 1'b1);
      end else begin
        for (int unsigned i = 0; i < count; i++) begin
          slot = (head + skip + i) % RING_DEPTH;
          queue_result(1'b1, seq_mem[slot], lvl_mem[slot], pay_mem[slot],
                       (i + 1 == count));
        end
      end
    end
  endtask

  task automatic check_field(input string label, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    otrb_pkg::otrb_out_t exp_item;
    if (rst_ni) begin
      // output first: an item leaving now was caused by an earlier input
      if (out_valid_i && !out_stall_i) begin
        if (readout_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time, out_i);
          errors++;
        end else begin
          exp_item = readout_q.pop_front();
          check_field("entry_valid", 64'(exp_item.entry_valid), 64'(out_i.entry_valid));
          check_field("sequence_res", exp_item.sequence_res, out_i.sequence_res);
          check_field("entry_level", 64'(exp_item.entry_level), 64'(out_i.entry_level));
          check_field("entry_payload", exp_item.entry_payload, out_i.entry_payload);
          check_field("stored_count", 64'(exp_item.stored_count),
                      64'(out_i.stored_count));
          check_field("dropped_count", exp_item.dropped_count, out_i.dropped_count);
          check_field("last", 64'(exp_item.last), 64'(out_i.last));
        end
      end
      if (in_valid_i && !in_stall_i) apply_ring_op(in_i);
    end
    fail_count_o <= errors;
    pending_o    <= readout_q.size();
  end

endmodule

// ===== tb/overwriting_trace_ring_buffer_tb.sv =====
// ----------------------------------------------------------------------------
// overwriting_trace_ring_buffer_tb
// Stimulus and verdict for the overwriting trace ring buffer.
// ----------------------------------------------------------------------------
// A short directed run covers empty snapshots, zero and oversized requests
// and the extremes of level and payload. A random run of pushes and
// snapshots follows, long enough to wrap the ring many times, in three
// phases of idling: slow receiver, slow sender, then none, the last one
// opening with a long receiver hold-off so the block backs up. The checker
// beside the block predicts and compares; this module only reports.
// ----------------------------------------------------------------------------
module overwriting_trace_ring_buffer_tb;

  localparam int N_RANDOM   = 420;
  localparam int HOLD_CYCLES = 300;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                src_valid  = 1'b0;
  otrb_pkg::otrb_in_t  src_item   = '0;
  logic                sink_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  otrb_pkg::otrb_out_t out_item;
  int                  fail_count;
  int                  pending;

  // idling rates, percent of cycles
  int        src_idle_pct  = 0;
  int        sink_idle_pct = 0;
  logic      hold_armed    = 1'b0;
  int        hold_left     = 0;
  logic      hold_done     = 1'b0;

  always #5 clk = ~clk;

  overwriting_trace_ring_buffer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (src_valid),
    .in_stall_o  (in_stall),
    .in_i        (src_item),
    .out_valid_o (out_valid),
    .out_stall_i (sink_stall),
    .out_o       (out_item)
  );

  otrb_tb_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (src_valid),
    .in_stall_i   (in_stall),
    .in_i         (src_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (sink_stall),
    .out_i        (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver: random stall per cycle, plus one long hold-off once armed.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      sink_stall <= 1'b1;
      hold_left  <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      sink_stall <= 1'b1;
      hold_left  <= HOLD_CYCLES - 1;
      hold_done  <= 1'b1;
    end else begin
      sink_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  // Offer one item, with random idle cycles ahead of it; returns once the
  // block has taken it.
  task automatic send_op(input otrb_pkg::op_e op,
                         input logic [otrb_pkg::LEVEL_W-1:0] lvl,
                         input logic [otrb_pkg::WORD_W-1:0] pay,
                         input logic [otrb_pkg::CNT_W-1:0] cnt);
    otrb_pkg::otrb_in_t item;
    item.operation = op;
    item.level     = lvl;
    item.payload   = pay;
    item.max_count = cnt;
    while ($urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin : stimulus
    int                         r;
    otrb_pkg::op_e              op;
    logic [otrb_pkg::CNT_W-1:0] cnt;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase one: sender idles a little, receiver a lot
    src_idle_pct  = 20;
    sink_idle_pct <= 58;

    // empty ring: zero and oversized requests both give one empty item
    send_op(otrb_pkg::OP_SNAPSHOT, 3'd7, '1, 7'd0);
    send_op(otrb_pkg::OP_SNAPSHOT, 3'd0, '0, 7'd127);
    send_op(otrb_pkg::OP_SNAPSHOT, 3'd5, 64'h0123_4567_89ab_cdef, 7'd64);
    // level and payload extremes
    send_op(otrb_pkg::OP_PUSH, 3'd0, 64'h0, 7'd0);
    send_op(otrb_pkg::OP_PUSH, 3'd7, 64'hffff_ffff_ffff_ffff, 7'd127);
    send_op(otrb_pkg::OP_PUSH, 3'd5, 64'haaaa_aaaa_aaaa_aaaa, 7'd85);
    send_op(otrb_pkg::OP_PUSH, 3'd2, 64'h5555_5555_5555_5555, 7'd42);
    // zero request on a non-empty ring is still empty
    send_op(otrb_pkg::OP_SNAPSHOT, 3'd0, '0, 7'd0);
    send_op(otrb_pkg::OP_SNAPSHOT, 3'd0, '0, 7'd1);
    send_op(otrb_pkg::OP_SNAPSHOT, 3'd0, '0, 7'd3);
    send_op(otrb_pkg::OP_SNAPSHOT, 3'd0, '0, 7'd4);
    // requests above the stored count saturate
    send_op(otrb_pkg::OP_SNAPSHOT, 3'd7, '1, 7'd5);
    send_op(otrb_pkg::OP_SNAPSHOT, 3'd7, '1, 7'd64);
    send_op(otrb_pkg::OP_SNAPSHOT, 3'd7, '1, 7'd127);
    send_op(otrb_pkg::OP_PUSH, 3'd1, 64'h8000_0000_0000_0001, 7'd64);
    send_op(otrb_pkg::OP_SNAPSHOT, 3'd0, '0, 7'd2);

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM / 3) begin
        src_idle_pct  = 58;
        sink_idle_pct <= 20;
      end else if (k == 2 * N_RANDOM / 3) begin
        // no idling; receiver holds off long enough to back up the input
        src_idle_pct  = 0;
        sink_idle_pct <= 0;
        hold_armed    <= 1'b1;
      end
      r = $urandom_range(99);
      if (r < 75) begin
        op  = otrb_pkg::OP_PUSH;
        cnt = otrb_pkg::CNT_W'($urandom_range(127));
      end else begin
        op = otrb_pkg::OP_SNAPSHOT;
        r  = $urandom_range(99);
        // mostly short readouts, a few full-ring and oversized ones
        if (r < 70)      cnt = otrb_pkg::CNT_W'($urandom_range(8));
        else if (r < 90) cnt = otrb_pkg::CNT_W'($urandom_range(63, 9));
        else if (r < 96) cnt = 7'd64;
        else             cnt = otrb_pkg::CNT_W'($urandom_range(127, 65));
      end
      send_op(op, otrb_pkg::LEVEL_W'($urandom_range(7)), {$urandom, $urandom}, cnt);
    end
    src_valid <= 1'b0;

    // checker counters are registered; step the clock before polling
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/otrb_pkg.sv
sv/otrb_ram.sv
sv/otrb_ctrl.sv
sv/otrb_dp.sv
sv/overwriting_trace_ring_buffer.sv
tb/otrb_tb_checker.sv
tb/overwriting_trace_ring_buffer_tb.sv
